### design/h2r_pkg.sv
// Package of the HSV to RGB converter: field widths, fixed-point constants,
// sector codes and the structures passed between pipeline stages.
// Depends on nothing; the converter top level and h2r_channel_sel use it.
package h2r_pkg;

    localparam int unsigned HUE_W   = 13;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FRAC_W  = 10;
    localparam int unsigned SEC_W   = 4;
    localparam int unsigned SPROD_W = 18;
    localparam int unsigned PY_W    = 16;
    localparam int unsigned QX_W    = 26;
    localparam int unsigned PEST_W  = 24;
    localparam int unsigned QEST_W  = 35;

    localparam logic [FRAC_W-1:0]  SECTOR_SPAN   = 10'd960;
    localparam logic [BYTE_W-1:0]  FULL_SCALE    = 8'd255;
    localparam logic [SPROD_W-1:0] PRODUCT_SCALE = 18'd244800;
    localparam int unsigned        SECTOR_COUNT  = 8;

    // Reciprocals for division by a constant: floor(2^K / divisor).
    localparam logic [PEST_W-1:0] P_RECIP = 24'd257;
    localparam int unsigned       P_SHIFT = 16;
    localparam logic [QEST_W-1:0] Q_RECIP = 35'd274;
    localparam int unsigned       Q_SHIFT = 26;

    localparam logic [SEC_W-1:0] SEC_RED     = 4'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW  = 4'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN   = 4'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN    = 4'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE    = 4'd4;

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] q_est;
        logic [BYTE_W-1:0] t_est;
        logic [QX_W-1:0]   q_num;
        logic [QX_W-1:0]   t_num;
    } t_levels;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

    // Number of whole sectors in the hue, by comparison against each boundary.
    function automatic logic [SEC_W-1:0] sector_of(input logic [HUE_W-1:0] hue);
        logic [SEC_W-1:0] sec;
        sec = '0;
        for (int k = 1; k <= SECTOR_COUNT; k++) begin
            if (hue >= HUE_W'(k * 960)) begin
                sec = SEC_W'(k);
            end
        end
        return sec;
    endfunction

endpackage

### design/h2r_if.sv
// Channel interfaces of the HSV to RGB converter: one for the HSV pixel
// transaction and one for the RGB result transaction.
// Depends on nothing; field widths follow the pixel formats.
interface h2r_hsv_if;
    logic        valid;
    logic        ready;
    logic [12:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;

    modport source(output valid, output hue, output saturation, output brightness,
                   input ready);
    modport sink(input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

interface h2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

### design/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: a five-stage pipeline from hue,
// saturation and value to red, green and blue bytes.
// Depends on h2r_pkg, h2r_if.sv and h2r_channel_sel.
//
//   Channel | Direction | Interface  | Transaction
//   i_hsv   | in        | h2r_hsv_if | hue, saturation, brightness
//   o_rgb   | out       | h2r_rgb_if | red, green, blue
//
// One transaction is accepted every cycle unless a stall reaches the first stage.
// A result passes through the stage chain: sector split, byte products, level
// numerators, reciprocal estimates, then correction and channel selection.
// Reset clears the stage valid bits only. A stall at the output holds each
// full stage, while empty stages further up still take new transactions.
module hsv_to_rgb_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h2r_hsv_if.sink       i_hsv,
    h2r_rgb_if.source     o_rgb
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    logic [h2r_pkg::SEC_W-1:0]   r1_sector;
    logic [h2r_pkg::FRAC_W-1:0]  r1_f;
    logic [h2r_pkg::BYTE_W-1:0]  r1_s;
    logic [h2r_pkg::BYTE_W-1:0]  r1_v;

    logic [h2r_pkg::SEC_W-1:0]   r2_sector;
    logic [h2r_pkg::BYTE_W-1:0]  r2_v;
    logic [h2r_pkg::SPROD_W-1:0] r2_sf;
    logic [h2r_pkg::SPROD_W-1:0] r2_sfc;
    logic [h2r_pkg::PY_W-1:0]    r2_py;

    logic [h2r_pkg::SEC_W-1:0]   r3_sector;
    logic [h2r_pkg::BYTE_W-1:0]  r3_v;
    logic [h2r_pkg::PY_W-1:0]    r3_py;
    logic [h2r_pkg::BYTE_W-1:0]  r3_pe;
    logic [h2r_pkg::QX_W-1:0]    r3_qx;
    logic [h2r_pkg::QX_W-1:0]    r3_tx;

    h2r_pkg::t_levels r4_lvl;
    h2r_pkg::t_rgb    r5_rgb;

    logic [h2r_pkg::SEC_W-1:0]   n1_sector;
    logic [h2r_pkg::HUE_W-1:0]   n1_f;
    logic [h2r_pkg::PEST_W-1:0]  w_p_prod;
    logic [h2r_pkg::QEST_W-1:0]  w_q_prod;
    logic [h2r_pkg::QEST_W-1:0]  w_t_prod;
    logic [h2r_pkg::PY_W-1:0]    w_p_rem;
    h2r_pkg::t_levels            n4_lvl;
    h2r_pkg::t_rgb               n5_rgb;

    assign w_en[STAGES-1] = !r_vld[STAGES-1] || o_rgb.ready;
    for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign i_hsv.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_hsv.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: sector number and position within the sector.
    assign n1_sector = h2r_pkg::sector_of(i_hsv.hue);
    assign n1_f      = i_hsv.hue - {9'd0, n1_sector} * 13'd960;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_sector <= n1_sector;
            r1_f      <= n1_f[h2r_pkg::FRAC_W-1:0];
            r1_s      <= i_hsv.saturation;
            r1_v      <= i_hsv.brightness;
        end
    end

    // Stage 2: saturation products and the numerator of p.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_sector <= r1_sector;
            r2_v      <= r1_v;
            r2_sf     <= {10'd0, r1_s} * {8'd0, r1_f};
            r2_sfc    <= {10'd0, r1_s} * {8'd0, h2r_pkg::SECTOR_SPAN - r1_f};
            r2_py     <= {8'd0, r1_v} * {8'd0, h2r_pkg::FULL_SCALE - r1_s};
        end
    end

    // Stage 3: numerators of q and t, and the quotient estimate of p.
    assign w_p_prod = {8'd0, r2_py} * h2r_pkg::P_RECIP;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_sector <= r2_sector;
            r3_v      <= r2_v;
            r3_py     <= r2_py;
            r3_pe     <= w_p_prod[h2r_pkg::P_SHIFT+7:h2r_pkg::P_SHIFT];
            r3_qx     <= {18'd0, r2_v} * {8'd0, h2r_pkg::PRODUCT_SCALE - r2_sf};
            r3_tx     <= {18'd0, r2_v} * {8'd0, h2r_pkg::PRODUCT_SCALE - r2_sfc};
        end
    end

    // Stage 4: correction of p and quotient estimates of q and t.
    assign w_q_prod = {9'd0, r3_qx} * h2r_pkg::Q_RECIP;
    assign w_t_prod = {9'd0, r3_tx} * h2r_pkg::Q_RECIP;
    assign w_p_rem  = r3_py - {8'd0, r3_pe} * {8'd0, h2r_pkg::FULL_SCALE};

    always_comb begin
        n4_lvl.sector = r3_sector;
        n4_lvl.v      = r3_v;
        n4_lvl.p      = (w_p_rem >= {8'd0, h2r_pkg::FULL_SCALE}) ? r3_pe + 8'd1 : r3_pe;
        n4_lvl.q_est  = w_q_prod[h2r_pkg::Q_SHIFT+7:h2r_pkg::Q_SHIFT];
        n4_lvl.t_est  = w_t_prod[h2r_pkg::Q_SHIFT+7:h2r_pkg::Q_SHIFT];
        n4_lvl.q_num  = r3_qx;
        n4_lvl.t_num  = r3_tx;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_lvl <= n4_lvl;
        end
    end

    // Stage 5: correction of q and t and the channel order of the sector.
    h2r_channel_sel u_channel_sel (
        .i_lvl (r4_lvl),
        .o_rgb (n5_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_rgb <= n5_rgb;
        end
    end

    assign o_rgb.valid = r_vld[STAGES-1];
    assign o_rgb.red   = r5_rgb.red;
    assign o_rgb.green = r5_rgb.green;
    assign o_rgb.blue  = r5_rgb.blue;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_hsv.ready)
        else $error("input not ready although the first stage is empty");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r1_f < h2r_pkg::SECTOR_SPAN))
        else $error("position within the sector out of range");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r1_sector <= 4'd8))
        else $error("sector number out of range");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_en[3]) |=> (r_vld[2] && $stable(r3_qx) && $stable(r3_tx)))
        else $error("stalled transaction in stage three was lost or changed");
`endif

endmodule

### design/h2r_channel_sel.sv
// Final stage logic of the converter: corrects the quotient estimates of the
// q and t levels and routes the levels to the channels by sector.
// Depends on h2r_pkg.
module h2r_channel_sel (
    input  h2r_pkg::t_levels i_lvl,
    output h2r_pkg::t_rgb    o_rgb
);

    logic [h2r_pkg::QX_W-1:0]   w_q_rem;
    logic [h2r_pkg::QX_W-1:0]   w_t_rem;
    logic [h2r_pkg::BYTE_W-1:0] w_q;
    logic [h2r_pkg::BYTE_W-1:0] w_t;

    // The estimate is at most one below the true quotient.
    assign w_q_rem = i_lvl.q_num - {18'd0, i_lvl.q_est} * {8'd0, h2r_pkg::PRODUCT_SCALE};
    assign w_t_rem = i_lvl.t_num - {18'd0, i_lvl.t_est} * {8'd0, h2r_pkg::PRODUCT_SCALE};
    assign w_q = (w_q_rem >= {8'd0, h2r_pkg::PRODUCT_SCALE}) ? i_lvl.q_est + 8'd1
                                                                : i_lvl.q_est;
    assign w_t = (w_t_rem >= {8'd0, h2r_pkg::PRODUCT_SCALE}) ? i_lvl.t_est + 8'd1
                                                                : i_lvl.t_est;

    always_comb begin
        unique case (i_lvl.sector)
            h2r_pkg::SEC_RED: begin
                o_rgb = '{red: i_lvl.v, green: w_t, blue: i_lvl.p};
            end
            h2r_pkg::SEC_YELLOW: begin
                o_rgb = '{red: w_q, green: i_lvl.v, blue: i_lvl.p};
            end
            h2r_pkg::SEC_GREEN: begin
                o_rgb = '{red: i_lvl.p, green: i_lvl.v, blue: w_t};
            end
            h2r_pkg::SEC_CYAN: begin
                o_rgb = '{red: i_lvl.p, green: w_q, blue: i_lvl.v};
            end
            h2r_pkg::SEC_BLUE: begin
                o_rgb = '{red: w_t, green: i_lvl.p, blue: i_lvl.v};
            end
            default: begin
                // The magenta sector, and hues beyond the circle.
                o_rgb = '{red: i_lvl.v, green: i_lvl.p, blue: w_q};
            end
        endcase
    end

endmodule
